// ===== rtl/text_console_char_placer_unit_defines.svh =====
// assertion helpers shared by the console modules
// every module that asserts has i_clk and active-low i_rst_n
`ifndef TEXT_CONSOLE_CHAR_PLACER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_PLACER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TCCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tccp_pkg.sv =====
package tccp_pkg;

    // character codes
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_BLANK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic do_put;
        logic do_read;
        logic load_read;
        logic clear_step;
        logic blank_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic item_read;
        logic item_scrolls;
        logic clear_last;
        logic blank_last;
    } t_status;

endpackage

// ===== rtl/tccp_in_if.sv =====
interface tccp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (
        output valid, operation, char_code, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, read_row, read_col,
        output ready
    );
endinterface

// ===== rtl/tccp_out_if.sv =====
interface tccp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_char;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_pos;
    logic        scrolled;

    modport source (
        output valid, read_char, cursor_row, cursor_col, cursor_pos, scrolled,
        input  ready
    );
    modport sink (
        input  valid, read_char, cursor_row, cursor_col, cursor_pos, scrolled,
        output ready
    );
endinterface

// ===== rtl/tccp_ctrl.sv =====
`include "text_console_char_placer_unit_defines.svh"

module tccp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tccp_pkg::t_status i_status,
    output tccp_pkg::t_cmd    o_cmd
);

    tccp_pkg::t_state r_state;
    tccp_pkg::t_state n_state;
    logic             accept;

    // item taken only when idle and the result register can take its result
    assign accept = (r_state == tccp_pkg::S_IDLE) && i_in_valid && i_status.out_free;

    // state register, reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tccp_pkg::S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = tccp_pkg::S_IDLE;
                end
            end
            tccp_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_status.item_read) begin
                        n_state = tccp_pkg::S_READ;
                    end else if (i_status.item_scrolls) begin
                        n_state = tccp_pkg::S_BLANK;
                    end
                end
            end
            tccp_pkg::S_READ: begin
                n_state = tccp_pkg::S_IDLE;
            end
            tccp_pkg::S_BLANK: begin
                if (i_status.blank_last) begin
                    n_state = tccp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tccp_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tccp_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            tccp_pkg::S_IDLE: begin
                o_in_ready    = i_status.out_free;
                o_cmd.do_put  = accept && !i_status.item_read;
                o_cmd.do_read = accept && i_status.item_read;
            end
            tccp_pkg::S_READ: begin
                o_cmd.load_read = 1'b1;
            end
            tccp_pkg::S_BLANK: begin
                o_cmd.blank_step = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `TCCP_ASSERT_NOW(a_single_cmd, 1'b1, ($onehot0({o_cmd.do_put, o_cmd.do_read, o_cmd.load_read, o_cmd.clear_step, o_cmd.blank_step})), "more than one datapath command at once")
    `TCCP_ASSERT_NEXT(a_scroll_blanks, (o_cmd.do_put && i_status.item_scrolls), (r_state == tccp_pkg::S_BLANK), "scrolling put did not start the row blank")
    `TCCP_ASSERT_NEXT(a_read_one_cycle, (r_state == tccp_pkg::S_READ), (r_state == tccp_pkg::S_IDLE), "read wait lasted more than one cycle")

endmodule

// ===== rtl/tccp_datapath.sv =====
`include "text_console_char_placer_unit_defines.svh"

module tccp_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tccp_pkg::t_cmd    i_cmd,
    output tccp_pkg::t_status o_status,
    input  logic              i_operation,
    input  logic [7:0]        i_char_code,
    input  logic [4:0]        i_read_row,
    input  logic [6:0]        i_read_col,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_read_char,
    output logic [4:0]        o_cursor_row,
    output logic [6:0]        o_cursor_col,
    output logic [10:0]       o_cursor_pos,
    output logic              o_scrolled
);

    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

    // screen memory, rows stored as a ring starting at r_top
    logic [7:0] r_mem [DEPTH];

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_top;
    logic [AW-1:0] r_sweep_addr;
    logic [CW-1:0] r_sweep_col;
    logic [7:0]    r_rd_data;
    logic          r_rd_ok;
    logic          r_out_valid;

    logic [RW:0]   cur_sum;
    logic [RW-1:0] cur_phys;
    logic [AW-1:0] cur_addr;
    logic [RW-1:0] rd_row;
    logic [RW:0]   rd_sum;
    logic [RW-1:0] rd_phys;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;
    logic          is_newline;
    logic          wrap;
    logic          last_row;
    logic          scroll;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_top;
    logic [AW-1:0] blank_base;
    logic [RW-1:0] pos_row;
    logic [CW-1:0] pos_col;
    logic [AW-1:0] pos_full;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    // cursor cell in the ring
    assign cur_sum  = {1'b0, r_row} + {1'b0, r_top};
    assign cur_phys = (cur_sum >= ROWS_W) ? RW'(cur_sum - ROWS_W) : RW'(cur_sum);
    assign cur_addr = AW'(cur_phys) * COLS_A + AW'(r_col);

    // read cell in the ring, address meaningless when out of range
    assign rd_row      = RW'(i_read_row);
    assign rd_sum      = {1'b0, rd_row} + {1'b0, r_top};
    assign rd_phys     = (rd_sum >= ROWS_W) ? RW'(rd_sum - ROWS_W) : RW'(rd_sum);
    assign rd_addr     = AW'(rd_phys) * COLS_A + AW'(i_read_col);
    assign rd_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    // cursor advance for a put
    assign is_newline = (i_char_code == tccp_pkg::NEWLINE_CODE);
    assign wrap       = is_newline || (r_col == LAST_COL);
    assign last_row   = (r_row == LAST_ROW);
    assign scroll     = wrap && last_row;
    assign n_row      = (wrap && !last_row) ? r_row + RW'(1) : r_row;
    assign n_col      = wrap ? '0 : r_col + CW'(1);
    assign n_top      = (r_top == LAST_ROW) ? '0 : r_top + RW'(1);
    // old top row becomes the new bottom row
    assign blank_base = AW'(r_top) * COLS_A;

    // linear cursor position for the result
    assign pos_row  = i_cmd.do_put ? n_row : r_row;
    assign pos_col  = i_cmd.do_put ? n_col : r_col;
    assign pos_full = AW'(pos_row) * COLS_A + AW'(pos_col);

    // status to the controller
    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_status.item_read    = (i_operation == tccp_pkg::OP_READ);
    assign o_status.item_scrolls = scroll;
    assign o_status.clear_last   = (r_sweep_addr == LAST_ADR);
    assign o_status.blank_last   = (r_sweep_col == LAST_COL);

    // memory write port
    assign mem_we = i_cmd.do_put || i_cmd.clear_step || i_cmd.blank_step;
    assign mem_wa = i_cmd.do_put ? cur_addr : r_sweep_addr;
    assign mem_wd = (i_cmd.do_put && !is_newline) ? i_char_code : tccp_pkg::BLANK_CODE;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_read) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= rd_in_range;
        end
    end

    // cursor, ring top and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_col  <= '0;
        end else begin
            if (i_cmd.do_put) begin
                r_row <= n_row;
                r_col <= n_col;
                if (scroll) begin
                    r_top        <= n_top;
                    r_sweep_addr <= blank_base;
                    r_sweep_col  <= '0;
                end
            end
            if (i_cmd.clear_step) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
            if (i_cmd.blank_step) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                r_sweep_col  <= r_sweep_col + CW'(1);
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_put || i_cmd.load_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_put) begin
            o_read_char  <= '0;
            o_cursor_row <= 5'(n_row);
            o_cursor_col <= 7'(n_col);
            o_cursor_pos <= 11'(pos_full);
            o_scrolled   <= scroll;
        end else if (i_cmd.load_read) begin
            o_read_char  <= r_rd_ok ? r_rd_data : '0;
            o_cursor_row <= 5'(r_row);
            o_cursor_col <= 7'(r_col);
            o_cursor_pos <= 11'(pos_full);
            o_scrolled   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    `TCCP_ASSERT_NOW(a_no_overwrite, (r_out_valid && !i_out_ready), (!(i_cmd.do_put || i_cmd.load_read)), "held result overwritten")
    `TCCP_ASSERT_NOW(a_col_range, 1'b1, (r_col <= LAST_COL), "cursor column past last column")
    `TCCP_ASSERT_NOW(a_row_range, 1'b1, ((r_row <= LAST_ROW) && (r_top <= LAST_ROW)), "cursor row or ring top past last row")

endmodule

// ===== rtl/text_console_char_placer_unit.sv =====
// results: a put's result is in the output register in the cycle after it is taken;
//   a read's result passes the registered memory read, then the output register
// input: one put per cycle while the result register is free; a read holds input until
//   its result loads, a scrolling put until the sweep blanks the new bottom row
// reset: synchronous, active low; cursor to 0,0, then a clearing pass over all
//   COLUMNS*ROWS cells (2000 by default) writes spaces before the first item is taken
module text_console_char_placer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tccp_in_if.sink       i_in,
    tccp_out_if.source    o_out
);

    tccp_pkg::t_cmd    cmd;
    tccp_pkg::t_status status;

    // sequencing of clear, put, read and row blank
    tccp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // screen memory, cursor and result register
    tccp_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_operation  (i_in.operation),
        .i_char_code  (i_in.char_code),
        .i_read_row   (i_in.read_row),
        .i_read_col   (i_in.read_col),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_read_char  (o_out.read_char),
        .o_cursor_row (o_out.cursor_row),
        .o_cursor_col (o_out.cursor_col),
        .o_cursor_pos (o_out.cursor_pos),
        .o_scrolled   (o_out.scrolled)
    );

endmodule

// ===== tb/text_console_char_placer_unit_test.sv =====
module text_console_char_placer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_INDEX = 420;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_ITEMS  = 60;
    localparam int CYCLE_LIMIT = 400000;

    // one item toward the block, plus a flag asking the sender to drain first
    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
        logic       wait_drain;
    } t_console_item;

    // one result from the block
    typedef struct packed {
        logic [7:0]  read_char;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_pos;
        logic        scrolled;
    } t_cursor_report;

    logic clk;
    logic rst_n;

    tccp_in_if  in_bus();
    tccp_out_if out_bus();

    text_console_char_placer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_console_item  pending_items[$];
    t_cursor_report cursor_reports_q[$];

    // shadow copy of the screen and cursor
    logic [7:0] shadow_screen [COLUMNS*ROWS];
    int         cur_row;
    int         cur_col;

    int  error_count;
    int  items_taken;
    int  cycle_count;
    bit  in_took;
    int  send_gap;
    int  sink_gap;
    int  long_hold;
    bit  hold_done;

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // no idling once the stimulus is nearly used up
    function automatic bit tail_phase();
        return pending_items.size() < TAIL_ITEMS;
    endfunction

    // move to the start of the next line, scrolling past the last row
    function bit line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < COLUMNS*(ROWS-1); i++)
                shadow_screen[i] = shadow_screen[i+COLUMNS];
            for (int i = COLUMNS*(ROWS-1); i < COLUMNS*ROWS; i++)
                shadow_screen[i] = tccp_pkg::BLANK_CODE;
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one item to the shadow console and form its result
    function t_cursor_report console_predict(t_console_item it);
        t_cursor_report r;
        int             here;
        int             pos;
        r = '0;
        if (it.operation == tccp_pkg::OP_READ) begin
            if (int'(it.read_row) < ROWS && int'(it.read_col) < COLUMNS)
                r.read_char = shadow_screen[int'(it.read_row)*COLUMNS + int'(it.read_col)];
        end else begin
            here = cur_row*COLUMNS + cur_col;
            if (it.char_code == tccp_pkg::NEWLINE_CODE) begin
                shadow_screen[here] = tccp_pkg::BLANK_CODE;
                r.scrolled = line_feed();
            end else begin
                shadow_screen[here] = it.char_code;
                cur_col++;
                if (cur_col >= COLUMNS)
                    r.scrolled = line_feed();
            end
        end
        pos = cur_row*COLUMNS + cur_col;
        r.cursor_row = cur_row[4:0];
        r.cursor_col = cur_col[6:0];
        r.cursor_pos = pos[10:0];
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    // queue one item, the drain flag lands on a fixed position
    task automatic add_item(input logic op, input logic [7:0] code,
                            input logic [4:0] row, input logic [6:0] col);
        t_console_item it;
        it.operation  = op;
        it.char_code  = code;
        it.read_row   = row;
        it.read_col   = col;
        it.wait_drain = (pending_items.size() == DRAIN_INDEX);
        pending_items.push_back(it);
    endtask

    task automatic add_put(input logic [7:0] code);
        add_item(tccp_pkg::OP_PUT, code, 5'($urandom_range(0, 31)),
                 7'($urandom_range(0, 127)));
    endtask

    task automatic add_read(input logic [4:0] row, input logic [6:0] col);
        add_item(tccp_pkg::OP_READ, 8'($urandom_range(0, 255)), row, col);
    endtask

    // random reads, mostly on screen, some past either edge
    task automatic add_random_read();
        logic [4:0] row;
        logic [6:0] col;
        row = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, ROWS-1))
                                           : 5'($urandom_range(ROWS, 31));
        col = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLUMNS-1))
                                           : 7'($urandom_range(COLUMNS, 127));
        add_read(row, col);
    endtask

    // text lines: mostly short, some long enough to wrap
    task automatic add_random_line();
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(0, 6);
        else if (pick < 90)
            len = $urandom_range(10, 40);
        else
            len = $urandom_range(COLUMNS-4, COLUMNS+4);
        for (int i = 0; i < len; i++) begin
            add_put(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                add_random_read();
        end
        if ($urandom_range(0, 99) < 85)
            add_put(tccp_pkg::NEWLINE_CODE);
    endtask

    // stimulus, reset and end of run
    initial begin
        int pick;
        in_bus.valid     = 1'b0;
        in_bus.operation = tccp_pkg::OP_PUT;
        in_bus.char_code = '0;
        in_bus.read_row  = '0;
        in_bus.read_col  = '0;
        out_bus.ready    = 1'b0;
        rst_n            = 1'b0;
        error_count      = 0;
        items_taken      = 0;
        cycle_count      = 0;
        in_took          = 1'b0;
        send_gap         = 0;
        sink_gap         = 0;
        long_hold        = 0;
        hold_done        = 1'b0;
        cur_row          = 0;
        cur_col          = 0;
        for (int i = 0; i < COLUMNS*ROWS; i++)
            shadow_screen[i] = tccp_pkg::BLANK_CODE;

        // directed: code extremes, newline, reads on and off the screen
        add_put(8'h41);
        add_put(8'hFF);
        add_put(8'h00);
        add_put(tccp_pkg::NEWLINE_CODE);
        add_put(tccp_pkg::NEWLINE_CODE);
        add_read(5'd0, 7'd0);
        add_read(5'd0, 7'd1);
        add_read(5'd0, 7'd2);
        add_read(5'd0, 7'd3);
        add_read(5'd1, 7'd0);
        add_read(5'(ROWS-1), 7'(COLUMNS-1));
        add_read(5'(ROWS-1), 7'd0);
        add_read(5'(ROWS), 7'd0);
        add_read(5'd0, 7'(COLUMNS));
        add_read(5'd31, 7'd127);
        add_put(8'h7E);
        add_read(5'd2, 7'd0);
        add_put(8'h55);
        add_put(8'hAA);
        add_read(5'd2, 7'd1);

        // random: text lines with reads and a little noise
        while (pending_items.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                add_random_read();
            else if (pick < 20)
                add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            else
                add_random_line();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all items to go in and all results to come back
        do begin
            @(posedge clk);
        end while (pending_items.size() != 0 || in_bus.valid || cursor_reports_q.size() != 0);
        repeat (20) @(posedge clk);

        if (error_count == 0) begin
            $display("[text_console_char_placer_unit] OK");
        end else begin
            $display("[text_console_char_placer_unit] ERROR");
        end
        $finish;
    end

    // sender: holds an item until taken, random gaps, drain before flagged item
    always @(negedge clk) begin
        t_console_item nxt;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!(in_bus.valid && !in_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (pending_items[0].wait_drain && cursor_reports_q.size() != 0) begin
                in_bus.valid <= 1'b0;
            end else if (!tail_phase() && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 14);
                in_bus.valid <= 1'b0;
            end else begin
                nxt = pending_items.pop_front();
                in_bus.valid     <= 1'b1;
                in_bus.operation <= nxt.operation;
                in_bus.char_code <= nxt.char_code;
                in_bus.read_row  <= nxt.read_row;
                in_bus.read_col  <= nxt.read_col;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            out_bus.ready <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            long_hold = HOLD_CYCLES - 1;
            out_bus.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_bus.ready <= 1'b0;
        end else if (!tail_phase() && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 14);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // monitor: check results, then predict for the item taken at this edge
    always @(posedge clk) begin
        t_cursor_report want;
        t_console_item  got_item;
        in_took <= in_bus.valid && in_bus.ready;
        if (rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (cursor_reports_q.size() == 0) begin
                    $error("result with no item outstanding: cursor_pos %0d",
                           out_bus.cursor_pos);
                    error_count++;
                end else begin
                    want = cursor_reports_q.pop_front();
                    check_field("read_char", want.read_char, out_bus.read_char);
                    check_field("cursor_row", want.cursor_row, out_bus.cursor_row);
                    check_field("cursor_col", want.cursor_col, out_bus.cursor_col);
                    check_field("cursor_pos", want.cursor_pos, out_bus.cursor_pos);
                    check_field("scrolled", want.scrolled, out_bus.scrolled);
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                got_item.operation  = in_bus.operation;
                got_item.char_code  = in_bus.char_code;
                got_item.read_row   = in_bus.read_row;
                got_item.read_col   = in_bus.read_col;
                got_item.wait_drain = 1'b0;
                cursor_reports_q.push_back(console_predict(got_item));
                items_taken++;
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[text_console_char_placer_unit] ERROR");
            $finish;
        end
    end

endmodule
